>>> rtl/i2rt_pkg.sv
// ============================================================================
// i2rt_pkg
// Shared types, character codes and helpers for the integer to text converter.
// ============================================================================
`default_nettype none

package i2rt_pkg;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_TEN   = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_MAX   = 6'd9;

    localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CH_A     = 7'd97;

    // Command from the sequencer to the serial divider.
    typedef struct packed {
        logic               start;
        logic [RADIX_W-1:0] radix;
    } div_ctl_t;

    // Status from the serial divider back to the sequencer.
    typedef struct packed {
        logic               done;
        logic               quot_zero;
        logic [RADIX_W-1:0] rem;
    } div_sts_t;

    // Clamps a register value into the supported radix range.
    function automatic logic [RADIX_W-1:0] radix_sat(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN)
        begin
            res = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Maps a digit value to its ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > DIGIT_MAX)
        begin
            res = CH_A + CHAR_W'(d) - CHAR_W'(RADIX_TEN);
        end
        else
        begin
            res = CH_ZERO + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/i2rt_divider.sv
// ============================================================================
// i2rt_divider
// Bit-serial restoring divider: one quotient bit per cycle by a small radix.
// ============================================================================
`default_nettype none

module i2rt_divider
    import i2rt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire div_ctl_t               ctl,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    output      logic [VALUE_WIDTH-1:0] quotient,
    output      div_sts_t               sts
);

    localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quot_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg;
    logic                   run_reg;
    logic                   done_reg;

    logic [RADIX_W:0]       trial;
    logic                   fits;
    logic                   last_step;

    // The remainder stays below the radix, so the shifted trial value fits
    // one bit wider than the radix.
    assign trial     = {rem_reg, quot_reg[VALUE_WIDTH-1]};
    assign fits      = trial >= {1'b0, radix_reg};
    assign last_step = bit_cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg    <= '0;
            rem_reg     <= '0;
            radix_reg   <= RADIX_MIN;
            bit_cnt_reg <= '0;
            run_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                quot_reg    <= dividend;
                rem_reg     <= '0;
                radix_reg   <= ctl.radix;
                bit_cnt_reg <= '0;
                run_reg     <= 1'b1;
            end
            else if (run_reg)
            begin
                quot_reg    <= {quot_reg[VALUE_WIDTH-2:0], fits};
                rem_reg     <= fits ? RADIX_W'(trial - {1'b0, radix_reg})
                                    : trial[RADIX_W-1:0];
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
                if (last_step)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient      = quot_reg;
    assign sts.done      = done_reg;
    assign sts.quot_zero = quot_reg == '0;
    assign sts.rem       = rem_reg;

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(run_reg))
        else $error("divider finished without running");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < radix_reg)
        else $error("remainder not below radix");

    a_run_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !ctl.start && !last_step) |=> run_reg)
        else $error("divider stopped early");

endmodule

`default_nettype wire

>>> rtl/int_to_radix_text.sv
// ============================================================================
// int_to_radix_text
// Converts a signed integer to its ASCII text in a radix from 2 to 36.
// ============================================================================
// Usage: write radix over the cfg channel while the block is idle (values
// below 2 act as 2, above 36 as 36). Pulse start with value while busy is
// low. The text then comes out most significant character first, one per
// strobe pulse, each visible for exactly one cycle; the receiver cannot
// stall it, so it must take every strobe. A '-' leads only in radix ten; in
// other radixes a negative value is written as its magnitude, and the most
// negative value is taken as magnitude 2^(VALUE_WIDTH-1). The final character
// carries last. Timing is set by the bit-serial divider, which produces one
// quotient bit per cycle; every digit takes a full divider pass, and each
// character then takes a digit store read state and an output state, with
// one more output state for a sign.
// ============================================================================
`default_nettype none

module int_to_radix_text
    import i2rt_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic signed [VALUE_WIDTH-1:0] value,
    input  wire logic                          cfg_valid,
    output      logic                          cfg_ready,
    input  wire logic [RADIX_W-1:0]            cfg_data,
    output      logic                          strobe,
    output      logic [CHAR_W-1:0]             char_code,
    output      logic                          last
);

    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   sign_reg;
    logic                   strobe_reg;
    logic [CHAR_W-1:0]      char_code_reg;
    logic                   last_reg;

    // Digit store: least significant digit at entry zero.
    logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];
    logic [RADIX_W-1:0]     rd_data_reg;

    div_ctl_t               div_ctl;
    div_sts_t               div_sts;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [VALUE_WIDTH-1:0] div_quotient;

    logic                   accept;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [RADIX_W-1:0]     radix_eff;
    logic                   digit_done;
    logic                   mem_we;
    logic [CNT_W-1:0]       count_m1;

    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Negation in unsigned arithmetic makes the most negative value come out
    // as 2^(VALUE_WIDTH-1) with no overflow.
    assign negative  = value[VALUE_WIDTH-1];
    assign magnitude = negative ? VALUE_WIDTH'(-$unsigned(value)) : $unsigned(value);
    assign radix_eff = radix_sat(radix_reg);

    assign digit_done = (state_reg == ST_DIVIDE) && div_sts.done;
    assign mem_we     = digit_done;
    assign count_m1   = count_reg - 1'b1;

    // A new item loads the magnitude; each finished digit with a nonzero
    // quotient restarts the divider on that quotient with no gap.
    assign div_ctl.start = accept || (digit_done && !div_sts.quot_zero);
    assign div_ctl.radix = radix_eff;
    assign div_dividend  = accept ? magnitude : div_quotient;

    i2rt_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .quotient (div_quotient),
        .sts      (div_sts)
    );

    // The radix register takes a write whenever the channel handshakes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radix_reg <= cfg_data;
        end
    end

    // Digit store with one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            digit_mem[count_reg[IDX_W-1:0]] <= div_sts.rem;
        end
        rd_data_reg <= digit_mem[count_m1[IDX_W-1:0]];
    end

    // Sequencer: collects digits from the divider, then replays them from
    // the most significant end, with the sign first when one is due.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sign_reg      <= 1'b0;
            strobe_reg    <= 1'b0;
            char_code_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        count_reg <= '0;
                        sign_reg  <= negative && (radix_eff == RADIX_TEN);
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_sts.done)
                    begin
                        count_reg <= count_reg + 1'b1;
                        if (div_sts.quot_zero)
                        begin
                            state_reg <= sign_reg ? ST_SIGN : ST_FETCH;
                        end
                    end
                end
                ST_SIGN:
                begin
                    char_code_reg <= CH_MINUS;
                    last_reg      <= 1'b0;
                    strobe_reg    <= 1'b1;
                    state_reg     <= ST_FETCH;
                end
                ST_FETCH:
                begin
                    count_reg <= count_m1;
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    char_code_reg <= digit_char(rd_data_reg);
                    last_reg      <= count_reg == '0;
                    strobe_reg    <= 1'b1;
                    state_reg     <= (count_reg == '0) ? ST_IDLE : ST_FETCH;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign strobe    = strobe_reg;
    assign char_code = char_code_reg;
    assign last      = last_reg;

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> state_reg == ST_IDLE)
        else $error("last character sent while item still in progress");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> count_reg < CNT_W'(VALUE_WIDTH))
        else $error("digit store overflow");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && count_reg == '0))
        else $error("accepted item did not start conversion");

    a_fetch_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FETCH |-> count_reg != '0)
        else $error("fetch with no digit left");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the integer to radix text converter.
// ============================================================================
// Every accepted value is converted to its expected text by a predictor in
// the scoreboard. Each strobed character is then compared with the oldest
// pending character. Directed values cover zero, plus and minus one, the
// extremes and the digit boundaries. Random phases follow, each at its own
// radix, including register values outside 2..36 that the block saturates.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import i2rt_pkg::*;

    localparam int VW          = 32;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 17;
    // The slowest item, in radix two, needs a full divider pass per digit
    // before its first character, so a gap far above that means a hang.
    localparam int STALL_LIMIT = 10000;
    localparam int TAIL_CYCLES = 40;

    // One expected character of a value's text.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } text_char_t;

    // Keeps its own copy of the radix register, predicts the text of each
    // accepted value and checks the strobed characters against it in order.
    class text_scoreboard;
        text_char_t         pending_chars[$];
        logic [RADIX_W-1:0] radix;
        int                 errors;

        function new();
            radix  = RADIX_RESET;
            errors = 0;
        endfunction

        // Builds the expected characters of one value, sign first if any.
        function void note_value(input logic signed [VW-1:0] v);
            logic [VW-1:0]      mag;
            logic [RADIX_W-1:0] base;
            logic [RADIX_W-1:0] digits [VW];
            logic               neg;
            int                 n;
            text_char_t         c;
            base = radix;
            if (base < RADIX_MIN)
            begin
                base = RADIX_MIN;
            end
            else if (base > RADIX_MAX)
            begin
                base = RADIX_MAX;
            end
            neg = v[VW-1];
            // In unsigned arithmetic the most negative value negates to 2^31.
            mag = neg ? (~v + 1'b1) : v;
            n   = 0;
            do
            begin
                digits[n] = RADIX_W'(mag % base);
                n++;
                mag = mag / base;
            end
            while (mag != 0);
            if (neg && base == RADIX_TEN)
            begin
                c.code = CH_MINUS;
                c.fin  = 1'b0;
                pending_chars.push_back(c);
            end
            for (int i = n - 1; i >= 0; i--)
            begin
                if (digits[i] > DIGIT_MAX)
                begin
                    c.code = CH_A + CHAR_W'(digits[i]) - CHAR_W'(RADIX_TEN);
                end
                else
                begin
                    c.code = CH_ZERO + CHAR_W'(digits[i]);
                end
                c.fin = (i == 0);
                pending_chars.push_back(c);
            end
        endfunction

        function void check_char(input logic [CHAR_W-1:0] code, input logic fin);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character %0d (last %0d) with no text pending",
                       code, fin);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
                errors++;
            end
            if (fin !== want.fin)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   start     = 1'b0;
    logic signed [VW-1:0]   value     = '0;
    logic                   cfg_valid = 1'b0;
    logic [RADIX_W-1:0]     cfg_data  = '0;
    logic                   busy;
    logic                   cfg_ready;
    logic                   strobe;
    logic [CHAR_W-1:0]      char_code;
    logic                   last;

    text_scoreboard board = new();

    // While set, neither the value side nor the register side idles.
    bit steady = 1'b0;

    int stall_cycles = 0;

    int_to_radix_text #(
        .VALUE_WIDTH(VW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Every strobe is one character; the bench cannot refuse it, so it is
    // checked at the edge that closes its cycle.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            board.check_char(char_code, last);
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || (cfg_valid && cfg_ready) || !rst_n)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Rolls an idle cycle with a chance of 14 in a hundred, unless a steady stretch is running.
    function automatic bit idle_roll();
        return !steady && ($urandom_range(0, 99) < 14);
    endfunction

    // Random value, mostly of random magnitude so that every digit count in
    // every radix shows up, sometimes one of the extremes.
    function automatic logic signed [VW-1:0] pick_value();
        logic [VW-1:0] v;
        int            w;
        case ($urandom_range(0, 19))
            0:       v = '0;
            1:       v = '1;
            2:       v = {1'b1, {(VW-1){1'b0}}};
            3:       v = {1'b0, {(VW-1){1'b1}}};
            4:       v = 1;
            default:
            begin
                w = $urandom_range(1, VW);
                v = $urandom;
                if (w < VW)
                begin
                    v = v & ((VW'(1) << w) - 1'b1);
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    v = ~v + 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    // Offers one value and returns at the edge where it is accepted. Start is
    // left high so that a following item can go out without a gap; it is lowered
    // only when an idle stretch comes first, before a radix write and at the end.
    task automatic send_value(input logic signed [VW-1:0] v);
        int gap;
        gap = 0;
        while (idle_roll())
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        value <= v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        board.note_value(v);
    endtask

    // Waits for the block to drain, then writes the radix register.
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (board.pending_chars.size() != 0 || busy);
        while (idle_roll())
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.radix = r;
    endtask

    initial
    begin
        logic [RADIX_W-1:0] phase_radix [PHASES];
        phase_radix = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd8, 6'd0,
                        6'd63, 6'd37, 6'd1, 6'd0, 6'd0, 6'd0};
        for (int p = 9; p < PHASES; p++)
        begin
            phase_radix[p] = RADIX_W'($urandom_range(0, 63));
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Radix after reset is ten: sign handling and the decimal extremes.
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(10);
        send_value(-10);
        send_value(32'sh7fffffff);
        send_value(32'sh80000000);

        // Highest radix: the letter digits and the last digit 'z'.
        write_radix(RADIX_MAX);
        send_value(35);
        send_value(36);
        send_value(-36);
        send_value(32'sh7fffffff);
        send_value(32'sh80000000);

        // Lowest radix: the longest texts, up to 32 characters.
        write_radix(RADIX_MIN);
        send_value(0);
        send_value(-1);
        send_value(32'sh80000000);
        send_value(32'sh7fffffff);

        // Register values outside the range are saturated to two and 36.
        write_radix(6'd0);
        send_value(5);
        write_radix(6'd1);
        send_value(-6);
        write_radix(6'd37);
        send_value(36);
        write_radix(6'd63);
        send_value(-1);

        // Random phases, each at its own radix; two of them run with no idle
        // cycles at all.
        for (int p = 0; p < PHASES; p++)
        begin
            write_radix(phase_radix[p]);
            steady = (p == 4 || p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_value(pick_value());
            end
        end
        steady = 1'b0;
        start <= 1'b0;

        while (board.pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.pending_chars.size() != 0)
        begin
            $error("%0d expected characters never arrived", board.pending_chars.size());
            board.errors++;
        end
        if (board.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/i2rt_pkg.sv
rtl/i2rt_divider.sv
rtl/int_to_radix_text.sv
tb/tb_top.sv
